// ===== sv/vtp_pkg.sv =====
// Shared constants for the vertex transform and projection block.
`default_nettype none
package vtp_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int COEF_COUNT      = 12;
    localparam int COEF_IDX_W      = 4;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_CNT_W     = 2;
    localparam int ROW_STRIDE      = 3;
    localparam int TRANS_BASE      = 9;
    localparam logic OP_COEF  = 1'b0;
    localparam logic OP_POINT = 1'b1;
endpackage
`default_nettype wire

// ===== sv/vtp_if.sv =====
// Handshake channels: input items, results, and the distance register write port.
`default_nettype none
interface vtp_in_if #(parameter int W = 32);
    logic                              valid;
    logic                              ready;
    logic                              operation;
    logic [vtp_pkg::COEF_IDX_W-1:0]    coef_index;
    logic signed [W-1:0]               coef_value;
    logic signed [W-1:0]               point_x;
    logic signed [W-1:0]               point_y;
    logic signed [W-1:0]               point_z;
    modport source (output valid, operation, coef_index, coef_value, point_x, point_y,
                    point_z, input ready);
    modport sink (input valid, operation, coef_index, coef_value, point_x, point_y,
                  point_z, output ready);
endinterface

interface vtp_out_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] trans_x;
    logic signed [W-1:0] trans_y;
    logic signed [W-1:0] trans_z;
    logic signed [W-1:0] proj_x;
    logic signed [W-1:0] proj_y;
    logic                divide_fault;
    modport source (output valid, trans_x, trans_y, trans_z, proj_x, proj_y, divide_fault,
                    input ready);
    modport sink (input valid, trans_x, trans_y, trans_z, proj_x, proj_y, divide_fault,
                  output ready);
endinterface

interface vtp_cfg_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== sv/vertex_transform_projection.sv =====
// Top level of the vertex transform and perspective projection block.
// Accepts one beat per cycle while ready is high: a coefficient write (op 0) or a point (op 1).
// Points stream at one per cycle while the output is not stalled, through a short queue
// into a pipeline of 2 multiply/round stages, a product-with-d stage, COORD_WIDTH
// restoring divide stages (one quotient bit per stage for both projections) and the
// output register; a stalled output holds the whole pipeline. A coefficient write is
// held until the queue is empty, so after a point it waits until that point leaves the
// queue, longer under back-pressure. The distance register takes a write every cycle.
`default_nettype none
module vertex_transform_projection #(
    parameter int COORD_WIDTH = vtp_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = vtp_pkg::FRAC_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    vtp_in_if.sink    in_ch,
    vtp_out_if.source out_ch,
    vtp_cfg_if.sink   cfg
);
    import vtp_pkg::*;

    logic                          q_valid, q_ready;
    logic signed [COORD_WIDTH-1:0] q_x, q_y, q_z, proj_dist;
    logic signed [COORD_WIDTH-1:0] matrix [COEF_COUNT];

    vtp_front #(.W(COORD_WIDTH), .F(FRAC_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_x       (q_x),
        .q_y       (q_y),
        .q_z       (q_z),
        .matrix    (matrix),
        .proj_dist (proj_dist)
    );

    vtp_back #(.W(COORD_WIDTH), .F(FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_x       (q_x),
        .q_y       (q_y),
        .q_z       (q_z),
        .matrix    (matrix),
        .proj_dist (proj_dist),
        .out_ch    (out_ch)
    );
endmodule
`default_nettype wire

// ===== sv/vtp_front.sv =====
// Front end: takes input beats, keeps the matrix and distance, queues points.
`default_nettype none
module vtp_front #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    vtp_in_if.sink                   in_ch,
    vtp_cfg_if.sink                  cfg,
    output logic                     q_valid,
    input  wire logic                q_ready,
    output logic signed [W-1:0]      q_x,
    output logic signed [W-1:0]      q_y,
    output logic signed [W-1:0]      q_z,
    output logic signed [W-1:0]      matrix [vtp_pkg::COEF_COUNT],
    output logic signed [W-1:0]      proj_dist
);
    import vtp_pkg::*;

    localparam logic [W-1:0] ONE = W'(1) << F;

    logic signed [W-1:0]    matrix_reg [COEF_COUNT];
    logic signed [W-1:0]    proj_dist_reg;
    logic signed [W-1:0]    qx_reg [QUEUE_DEPTH];
    logic signed [W-1:0]    qy_reg [QUEUE_DEPTH];
    logic signed [W-1:0]    qz_reg [QUEUE_DEPTH];
    logic                   wr_ptr_reg, wr_ptr_next;
    logic                   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   accept, push, pop, coef_wr;

    // a coefficient write waits until every queued point has read the matrix
    assign in_ch.ready = (in_ch.operation == OP_POINT) ?
                         (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH)) : (count_reg == '0);
    assign accept  = in_ch.valid && in_ch.ready;
    assign push    = accept && (in_ch.operation == OP_POINT);
    assign coef_wr = accept && (in_ch.operation == OP_COEF) &&
                     (in_ch.coef_index < COEF_IDX_W'(COEF_COUNT));
    assign pop     = q_valid && q_ready;
    assign cfg.ready = 1'b1;

    assign wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign q_valid   = (count_reg != '0);
    assign q_x       = qx_reg[rd_ptr_reg];
    assign q_y       = qy_reg[rd_ptr_reg];
    assign q_z       = qz_reg[rd_ptr_reg];
    assign matrix    = matrix_reg;
    assign proj_dist = proj_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            count_reg     <= '0;
            proj_dist_reg <= ONE;
            for (int i = 0; i < COEF_COUNT; i++)
            begin
                matrix_reg[i] <= (i % 4 == 0) ? ONE : '0;
            end
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            if (cfg.valid)
            begin
                proj_dist_reg <= cfg.data;
            end
            if (coef_wr)
            begin
                matrix_reg[in_ch.coef_index] <= in_ch.coef_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            qx_reg[wr_ptr_reg] <= in_ch.point_x;
            qy_reg[wr_ptr_reg] <= in_ch.point_y;
            qz_reg[wr_ptr_reg] <= in_ch.point_z;
        end
    end

    a_coef_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.operation == OP_COEF) |-> (count_reg == '0))
        else $error("coefficient write taken with points queued");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH)) |-> !push)
        else $error("point taken into a full queue");
endmodule
`default_nettype wire

// ===== sv/vtp_back.sv =====
// Back end: matrix multiply, rounding, products with d, pipelined divide, output register.
`default_nettype none
module vtp_back #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_valid,
    output logic                     q_ready,
    input  wire logic signed [W-1:0] q_x,
    input  wire logic signed [W-1:0] q_y,
    input  wire logic signed [W-1:0] q_z,
    input  wire logic signed [W-1:0] matrix [vtp_pkg::COEF_COUNT],
    input  wire logic signed [W-1:0] proj_dist,
    vtp_out_if.source                out_ch
);
    import vtp_pkg::*;

    localparam int ACC_W = 2 * W + 2;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (F - 1);

    typedef struct packed {
        logic [W-1:0] rem;
        logic [W-1:0] lo;
        logic [W-1:0] quo;
        logic         neg;
        logic         ovf;
        logic         nz;
    } lane_t;

    typedef struct packed {
        logic                valid;
        logic signed [W-1:0] tx;
        logic signed [W-1:0] ty;
        logic signed [W-1:0] tz;
        logic [W-1:0]        den;
        logic                zden;
        lane_t               lx;
        lane_t               ly;
    } item_t;

    function automatic lane_t div_step(lane_t l, logic [W-1:0] den);
        lane_t      r;
        logic [W:0] sh;
        logic [W:0] trial;
        r     = l;
        sh    = {l.rem, l.lo[W-1]};
        trial = sh - {1'b0, den};
        r.lo  = l.lo << 1;
        if (!trial[W])
        begin
            r.rem = trial[W-1:0];
            r.quo = {l.quo[W-2:0], 1'b1};
        end
        else
        begin
            r.rem = sh[W-1:0];
            r.quo = {l.quo[W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic item_t div_stage(item_t it);
        item_t r;
        r    = it;
        r.lx = div_step(it.lx, it.den);
        r.ly = div_step(it.ly, it.den);
        return r;
    endfunction

    function automatic lane_t lane_init(logic signed [2*W-1:0] num, logic tzneg,
                                        logic [W-1:0] den);
        lane_t          r;
        logic [2*W-1:0] mag;
        mag   = num[2*W-1] ? (2*W)'(-num) : num;
        r.rem = mag[2*W-1:W];
        r.lo  = mag[W-1:0];
        r.quo = '0;
        r.neg = (num[2*W-1] == tzneg);
        r.ovf = (mag[2*W-1:W] >= den);
        r.nz  = (mag != '0);
        return r;
    endfunction

    // {fault, value}
    function automatic logic [W:0] lane_done(lane_t l, logic zden);
        logic [W:0] r;
        if (zden)
        begin
            r = {1'b1, (l.nz ? (l.neg ? MAXV : MINV) : {W{1'b0}})};
        end
        else if (l.ovf)
        begin
            r = {1'b1, (l.neg ? MINV : MAXV)};
        end
        else if (l.neg)
        begin
            r = (l.quo <= MINV) ? {1'b0, W'(-l.quo)} : {1'b1, MINV};
        end
        else
        begin
            r = (l.quo <= MAXV) ? {1'b0, l.quo} : {1'b1, MAXV};
        end
        return r;
    endfunction

    function automatic logic signed [W-1:0] round_sat(logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] sh;
        sh = (acc + HALF) >>> F;
        if (sh[ACC_W-1:W-1] == '0 || sh[ACC_W-1:W-1] == '1)
        begin
            return sh[W-1:0];
        end
        return sh[ACC_W-1] ? MINV : MAXV;
    endfunction

    logic                    en;
    logic                    s1_valid_reg;
    logic signed [2*W-1:0]   prod_reg [9];
    logic signed [W-1:0]     tr_reg [ROW_STRIDE];
    logic                    s2_valid_reg;
    logic signed [W-1:0]     t2_reg [ROW_STRIDE];
    item_t                   dv_reg [W+1];
    logic signed [2*W-1:0]   num_x, num_y;
    logic [W-1:0]            den;
    logic signed [ACC_W-1:0] acc [ROW_STRIDE];
    logic [W:0]              res_x, res_y;
    logic                    out_valid_reg;
    logic signed [W-1:0]     tx_reg, ty_reg, tz_reg, px_reg, py_reg;
    logic                    fault_reg;

    // whole pipeline moves together; the output register is the skid point
    assign en      = !out_valid_reg || out_ch.ready;
    assign q_ready = en;

    always_comb
    begin
        for (int c = 0; c < ROW_STRIDE; c++)
        begin
            acc[c] = ACC_W'(prod_reg[c]) + ACC_W'(prod_reg[ROW_STRIDE + c]) +
                     ACC_W'(prod_reg[2 * ROW_STRIDE + c]) + (ACC_W'(tr_reg[c]) <<< F);
        end
    end

    assign num_x = (2*W)'(proj_dist) * (2*W)'(t2_reg[0]);
    assign num_y = (2*W)'(proj_dist) * (2*W)'(t2_reg[1]);
    assign den   = t2_reg[2][W-1] ? W'(-t2_reg[2]) : t2_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            dv_reg[0]    <= '0;
        end
        else if (en)
        begin
            s1_valid_reg    <= q_valid;
            s2_valid_reg    <= s1_valid_reg;
            dv_reg[0].valid <= s2_valid_reg;
            dv_reg[0].tx    <= t2_reg[0];
            dv_reg[0].ty    <= t2_reg[1];
            dv_reg[0].tz    <= t2_reg[2];
            dv_reg[0].den   <= den;
            dv_reg[0].zden  <= (t2_reg[2] == '0);
            dv_reg[0].lx    <= lane_init(num_x, t2_reg[2][W-1], den);
            dv_reg[0].ly    <= lane_init(num_y, t2_reg[2][W-1], den);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < ROW_STRIDE; c++)
            begin
                prod_reg[c]                  <= (2*W)'(q_x) * (2*W)'(matrix[c]);
                prod_reg[ROW_STRIDE + c]     <= (2*W)'(q_y) * (2*W)'(matrix[ROW_STRIDE + c]);
                prod_reg[2 * ROW_STRIDE + c] <= (2*W)'(q_z) *
                                                (2*W)'(matrix[2 * ROW_STRIDE + c]);
                tr_reg[c]                    <= matrix[TRANS_BASE + c];
                t2_reg[c]                    <= round_sat(acc[c]);
            end
        end
    end

    for (genvar k = 0; k < W; k++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k+1] <= '0;
            end
            else if (en)
            begin
                dv_reg[k+1] <= div_stage(dv_reg[k]);
            end
        end
    end

    assign res_x = lane_done(dv_reg[W].lx, dv_reg[W].zden);
    assign res_y = lane_done(dv_reg[W].ly, dv_reg[W].zden);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_reg[W].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tx_reg    <= dv_reg[W].tx;
            ty_reg    <= dv_reg[W].ty;
            tz_reg    <= dv_reg[W].tz;
            px_reg    <= res_x[W-1:0];
            py_reg    <= res_y[W-1:0];
            fault_reg <= res_x[W] | res_y[W];
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.trans_x      = tx_reg;
    assign out_ch.trans_y      = ty_reg;
    assign out_ch.trans_z      = tz_reg;
    assign out_ch.proj_x       = px_reg;
    assign out_ch.proj_y       = py_reg;
    assign out_ch.divide_fault = fault_reg;

    a_zero_depth_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.trans_z == '0) |-> out_ch.divide_fault)
        else $error("zero depth without fault");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> ($stable(s1_valid_reg) && $stable(s2_valid_reg)))
        else $error("pipeline moved during output stall");
    a_take_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready) |=> s1_valid_reg)
        else $error("taken point lost at first stage");
endmodule
`default_nettype wire

// ===== tb/vertex_transform_projection_test.sv =====
// Testbench for the vertex transform and projection block: directed and random stimulus checked by a predictor.
`timescale 1ns / 100ps
`default_nettype none
module vertex_transform_projection_test;
    import vtp_pkg::*;

    localparam int W = 32;
    localparam int FB = 16;
    localparam int PIPE_LAT = W + 12;
    localparam int CYCLE_LIMIT = 600000;

    typedef logic signed [W-1:0] coord_t;
    typedef logic signed [127:0] wide_t;

    typedef struct {
        coord_t tx;
        coord_t ty;
        coord_t tz;
        coord_t px;
        coord_t py;
        logic   fault;
    } vertex_result_t;

    class projection_scoreboard;
        coord_t         coefs[COEF_COUNT];
        coord_t         distance;
        vertex_result_t expected_results[$];
        int             errors;

        function new();
            foreach (coefs[i])
                coefs[i] = '0;
            coefs[0] = coord_t'(1 << FB);
            coefs[4] = coord_t'(1 << FB);
            coefs[8] = coord_t'(1 << FB);
            distance = coord_t'(1 << FB);
            errors = 0;
        endfunction

        function coord_t clamp(wide_t v, output logic hit);
            wide_t hi;
            wide_t lo;
            hi = wide_t'(coord_t'({1'b0, {(W-1){1'b1}}}));
            lo = wide_t'(coord_t'({1'b1, {(W-1){1'b0}}}));
            hit = 1'b0;
            if (v > hi)
            begin
                hit = 1'b1;
                return hi[W-1:0];
            end
            if (v < lo)
            begin
                hit = 1'b1;
                return lo[W-1:0];
            end
            return v[W-1:0];
        endfunction

        // row vector [x y z 1] times column col, round half up, saturate
        function coord_t transform_col(coord_t x, coord_t y, coord_t z, int col);
            wide_t acc;
            logic  hit;
            acc = wide_t'(coefs[TRANS_BASE + col]) <<< FB;
            acc = acc + wide_t'(x) * wide_t'(coefs[col]);
            acc = acc + wide_t'(y) * wide_t'(coefs[ROW_STRIDE + col]);
            acc = acc + wide_t'(z) * wide_t'(coefs[2*ROW_STRIDE + col]);
            acc = (acc + (wide_t'(1) <<< (FB - 1))) >>> FB;
            return clamp(acc, hit);
        endfunction

        function coord_t perspective(coord_t v, coord_t depth, inout logic fault);
            wide_t num;
            wide_t q;
            logic  hit;
            num = wide_t'(distance) * wide_t'(v);
            if (depth == 0)
            begin
                fault = 1'b1;
                if (num == 0)
                    return '0;
                return (num < 0) ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end
            q = num / (-wide_t'(depth));
            perspective = clamp(q, hit);
            if (hit)
                fault = 1'b1;
        endfunction

        function void note_input(logic op, logic [COEF_IDX_W-1:0] idx, coord_t value,
                                 coord_t x, coord_t y, coord_t z);
            vertex_result_t r;
            if (op == OP_COEF)
            begin
                if (idx < COEF_COUNT)
                    coefs[idx] = value;
                return;
            end
            r.fault = 1'b0;
            r.tx = transform_col(x, y, z, 0);
            r.ty = transform_col(x, y, z, 1);
            r.tz = transform_col(x, y, z, 2);
            r.px = perspective(r.tx, r.tz, r.fault);
            r.py = perspective(r.ty, r.tz, r.fault);
            expected_results = {expected_results, r};
        endfunction

        function void check_result(vertex_result_t got);
            vertex_result_t e;
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing expected: trans_x %0d", got.tx);
                errors++;
                return;
            end
            e = expected_results.pop_front();
            if (got.tx !== e.tx)
            begin
                $error("trans_x expected %0d actual %0d", e.tx, got.tx);
                errors++;
            end
            if (got.ty !== e.ty)
            begin
                $error("trans_y expected %0d actual %0d", e.ty, got.ty);
                errors++;
            end
            if (got.tz !== e.tz)
            begin
                $error("trans_z expected %0d actual %0d", e.tz, got.tz);
                errors++;
            end
            if (got.px !== e.px)
            begin
                $error("proj_x expected %0d actual %0d", e.px, got.px);
                errors++;
            end
            if (got.py !== e.py)
            begin
                $error("proj_y expected %0d actual %0d", e.py, got.py);
                errors++;
            end
            if (got.fault !== e.fault)
            begin
                $error("divide_fault expected %0b actual %0b", e.fault, got.fault);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycles;
    logic gaps_on;

    vtp_in_if  #(W) in_ch();
    vtp_out_if #(W) out_ch();
    vtp_cfg_if #(W) cfg();

    projection_scoreboard sb;

    vertex_transform_projection dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .cfg(cfg)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.note_input(in_ch.operation, in_ch.coef_index, in_ch.coef_value,
                          in_ch.point_x, in_ch.point_y, in_ch.point_z);
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result('{out_ch.trans_x, out_ch.trans_y, out_ch.trans_z,
                              out_ch.proj_x, out_ch.proj_y, out_ch.divide_fault});
    end

    function int rand_gap();
        int p;
        p = $urandom_range(0, 99);
        if (!gaps_on || p < 60)
            return 0;
        if (p < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // result side back-pressure
    initial
    begin
        int n;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            n = rand_gap();
            if (n == 0)
                out_ch.ready <= 1'b1;
            else
            begin
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    function coord_t rand_coord();
        case ($urandom_range(0, 9))
            0: return coord_t'($urandom);
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return coord_t'(int'($urandom_range(0, 2097152)) - 1048576);
        endcase
    endfunction

    task send_beat(logic op, logic [COEF_IDX_W-1:0] idx, coord_t value,
                   coord_t x, coord_t y, coord_t z);
        int n;
        n = rand_gap();
        if (n > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.operation  <= op;
        in_ch.coef_index <= idx;
        in_ch.coef_value <= value;
        in_ch.point_x    <= x;
        in_ch.point_y    <= y;
        in_ch.point_z    <= z;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task send_point(coord_t x, coord_t y, coord_t z);
        send_beat(OP_POINT, COEF_IDX_W'($urandom), coord_t'($urandom), x, y, z);
    endtask

    task send_coef(logic [COEF_IDX_W-1:0] idx, coord_t value);
        send_beat(OP_COEF, idx, value, coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom));
    endtask

    // distance register only changes once the pipeline has drained
    task write_distance(coord_t d);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= d;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        sb.distance = d;
        cfg.valid <= 1'b0;
    endtask

    task load_random_matrix();
        for (int i = 0; i < COEF_COUNT; i++)
        begin
            if (i == TRANS_BASE + 2)
                send_coef(COEF_IDX_W'(i), coord_t'(-int'($urandom_range(2, 40)) <<< FB));
            else
                send_coef(COEF_IDX_W'(i), coord_t'(int'($urandom_range(0, 262144)) - 131072));
        end
    endtask

    initial
    begin
        coord_t distances[6];
        sb = new();
        cycles = 0;
        gaps_on = 1'b1;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_COEF;
        in_ch.coef_index = '0;
        in_ch.coef_value = '0;
        in_ch.point_x = '0;
        in_ch.point_y = '0;
        in_ch.point_z = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity matrix, d = 1.0
        send_point(32'sh0001_0000, 32'sh0002_0000, -32'sh0004_0000);
        send_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0000_0000);    // zero depth
        send_point(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);    // zero depth, zero dividend
        send_point(32'sh7fffffff, 32'sh80000000, 32'sh0000_0001);      // quotient overflow
        send_point(32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_point(-32'sh0003_8000, 32'sh0001_8000, 32'sh0002_0000);
        send_coef(4'd12, 32'sh7fffffff);                               // ignored index
        send_coef(4'd15, 32'sh80000000);
        send_point(32'sh0001_0000, 32'sh0001_0000, -32'sh0001_0000);
        send_coef(4'd0, 32'sh7fffffff);                                // transform saturation
        send_coef(4'd3, 32'sh7fffffff);
        send_point(32'sh7fffffff, 32'sh7fffffff, -32'sh0001_0000);
        send_point(32'sh80000000, 32'sh7fffffff, -32'sh0001_0000);
        send_coef(4'd0, 32'sh80000000);
        send_coef(4'd3, 32'sh0000_0000);
        send_coef(4'd9, 32'sh0000_8000);                               // rounding half up
        send_coef(4'd10, 32'sh7fffffff);
        send_coef(4'd11, -32'sh0000_8000);
        send_point(32'sh0000_0001, 32'sh0000_0003, 32'sh0000_0001);
        send_point(32'shffff_ffff, 32'shffff_fffd, 32'shffff_ffff);

        distances[0] = 32'sh0001_0000;
        distances[1] = 32'sh7fffffff;
        distances[2] = 32'sh80000000;
        distances[3] = 32'sh0000_0000;
        distances[4] = coord_t'($urandom);
        distances[5] = -32'sh0002_8000;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_distance(distances[ph]);
            gaps_on = (ph != 2);
            load_random_matrix();
            for (int k = 0; k < 210; k++)
            begin
                if ($urandom_range(0, 99) < 12)
                    send_coef(COEF_IDX_W'($urandom_range(0, 15)), rand_coord());
                else if ($urandom_range(0, 99) < 3)
                    load_random_matrix();
                else
                    send_point(rand_coord(), rand_coord(), rand_coord());
            end
        end
        gaps_on = 1'b1;
        in_ch.valid <= 1'b0;

        @(posedge clk);
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT) @(posedge clk);
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire
